### sv/uvs_pkg.sv
// shared types, constants and arithmetic helpers of the uv sphere mesh generator
package uvs_pkg;

	// result kinds carried on tuser
	typedef enum logic [1:0] {
		KIND_VERTEX   = 2'd0,
		KIND_TRIANGLE = 2'd1,
		KIND_REJECT   = 2'd2
	} kind_t;

	// configuration register indexes
	localparam logic [1:0] REG_RADIUS  = 2'd0;
	localparam logic [1:0] REG_SECTORS = 2'd1;
	localparam logic [1:0] REG_STACKS  = 2'd2;

	localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
	localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;
	localparam logic signed [63:0] POS_LIMIT    = 64'sd16777215;
	localparam logic signed [63:0] NORM_LIMIT   = 64'sd16384;

	// per grid point control that rides along the pipeline
	typedef struct packed {
		logic        rej;
		logic        tri_a;
		logic        tri_b;
		logic [16:0] k1;
		logic [16:0] k2;
	} side_t;

	typedef struct packed {
		logic                neg;
		logic signed [33:0]  z;
	} fold_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
	} rot_t;

	// arctangent of 2^-k in turns * 2^32
	function automatic logic signed [33:0] atan_turn(input int k);
		case (k)
			0:  return 34'sd536870912;
			1:  return 34'sd316933406;
			2:  return 34'sd167458907;
			3:  return 34'sd85004756;
			4:  return 34'sd42667331;
			5:  return 34'sd21354465;
			6:  return 34'sd10679838;
			7:  return 34'sd5340245;
			8:  return 34'sd2670163;
			9:  return 34'sd1335087;
			10: return 34'sd667544;
			11: return 34'sd333772;
			12: return 34'sd166886;
			13: return 34'sd83443;
			14: return 34'sd41722;
			15: return 34'sd20861;
			16: return 34'sd10430;
			17: return 34'sd5215;
			18: return 34'sd2608;
			19: return 34'sd1304;
			20: return 34'sd652;
			21: return 34'sd326;
			22: return 34'sd163;
			23: return 34'sd81;
			default: return 34'sd0;
		endcase
	endfunction

	// fold a turn fraction into [-1/4, +1/4] turn
	function automatic fold_t fold_angle(input logic [31:0] a);
		fold_t f;
		f.z   = 34'(signed'(a));
		f.neg = 1'b0;
		if (f.z > QUARTER_TURN) begin
			f.z   = f.z - HALF_TURN;
			f.neg = 1'b1;
		end else if (f.z < -QUARTER_TURN) begin
			f.z   = f.z + HALF_TURN;
			f.neg = 1'b1;
		end
		return f;
	endfunction

	// one cordic rotation step with floor shifts
	function automatic rot_t rot_step(input rot_t r, input int k);
		rot_t o;
		if (r.z >= 0) begin
			o.x = r.x - (r.y >>> k);
			o.y = r.y + (r.x >>> k);
			o.z = r.z - atan_turn(k);
		end else begin
			o.x = r.x + (r.y >>> k);
			o.y = r.y - (r.x >>> k);
			o.z = r.z + atan_turn(k);
		end
		return o;
	endfunction

	// round half up by a right shift, then clip to +-lim
	function automatic logic signed [63:0] rnd_sat(input logic signed [63:0] v,
			input int sh, input logic signed [63:0] lim);
		logic signed [63:0] r;
		r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
		if (r > lim) return lim;
		if (r < -lim) return -lim;
		return r;
	endfunction

endpackage

### sv/uv_sphere_mesh_generator.sv
// uv sphere grid point to vertex and triangle generator, fully pipelined
// throughput: one grid point per cycle while each gives one result and m_axis_tready is high; a point
//   with triangles holds the output until each of its results (up to three) is taken
// pipeline: input reg, 32 divider steps, angle fold, cordic stages, 5 multiply stages
// reset: arst_n clears valid bits and the result counter, config returns to defaults
module uv_sphere_mesh_generator #(
	parameter int MAX_SECTORS   = 256,
	parameter int MAX_STACKS    = 256,
	parameter int CORDIC_STAGES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// config write port
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [23:0]  cfg_data,
	// grid point stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [23:0]  s_axis_tdata,   // stack_index[8:0], sector_index[17:9]
	// result stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// pos_x[24:0], pos_y[49:25], pos_z[74:50], norm_x[90:75], norm_y[106:91],
	// norm_z[122:107], corner_a[139:123], corner_b[156:140], corner_c[173:157]
	output logic [175:0] m_axis_tdata,
	output logic [1:0]   m_axis_tuser,   // result_kind[1:0]
	output logic         m_axis_tlast    // last_of_run
);

	localparam int DIV_STEPS = 32;
	localparam int CS        = CORDIC_STAGES;
	localparam int NST       = DIV_STEPS + CS + 7;   // total register stages
	localparam logic [8:0] SEC_HI = 9'((MAX_SECTORS > 511) ? 511 : MAX_SECTORS);
	localparam logic [8:0] STK_HI = 9'((MAX_STACKS > 511) ? 511 : MAX_STACKS);

	// configuration registers
	logic [23:0] radius_q;
	logic [8:0]  sectors_q;
	logic [8:0]  stacks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= 24'd65536;
			sectors_q <= 9'd32;
			stacks_q  <= 9'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				uvs_pkg::REG_RADIUS:  radius_q  <= cfg_data;
				uvs_pkg::REG_SECTORS: sectors_q <= cfg_data[8:0];
				uvs_pkg::REG_STACKS:  stacks_q  <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// counts clamped into their legal range
	logic [8:0] sec_c, stk_c;
	always_comb begin
		if (sectors_q < 9'd3)       sec_c = 9'd3;
		else if (sectors_q > SEC_HI) sec_c = SEC_HI;
		else                        sec_c = sectors_q;
		if (stacks_q < 9'd2)        stk_c = 9'd2;
		else if (stacks_q > STK_HI) stk_c = STK_HI;
		else                        stk_c = stacks_q;
	end

	// global advance: the whole pipe moves when the output is free or finishing
	logic              adv;
	logic              last_c;
	logic [NST-1:0]    vld_q;
	logic [1:0]        sel_q;

	assign adv           = !vld_q[NST-1] || (m_axis_tready && last_c);
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
		end
	end

	// input decode: range check and triangle corner indexes
	logic [8:0]      stack_i, sector_j;
	logic [18:0]     k1_w;
	uvs_pkg::side_t  side_in;

	assign stack_i  = s_axis_tdata[8:0];
	assign sector_j = s_axis_tdata[17:9];
	assign k1_w     = 19'(stack_i) * (19'(sec_c) + 19'd1) + 19'(sector_j);

	always_comb begin
		side_in.rej   = (stack_i > stk_c) || (sector_j > sec_c);
		side_in.tri_a = !side_in.rej && (stack_i < stk_c) && (sector_j < sec_c)
			&& (stack_i != 9'd0);
		side_in.tri_b = !side_in.rej && (stack_i < stk_c) && (sector_j < sec_c)
			&& (stack_i != stk_c - 9'd1);
		side_in.k1    = k1_w[16:0];
		side_in.k2    = 17'(k1_w + 19'(sec_c) + 19'd1);
	end

	// side band shift line, one entry per stage
	uvs_pkg::side_t side_sp [NST];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_sp[0] <= side_in;
			for (int k = 1; k < NST; k++) side_sp[k] <= side_sp[k-1];
		end
	end

	// restoring dividers: quotient of i*2^32/stacks and j*2^32/sectors,
	// one quotient bit per stage, top bit settled at the input stage
	logic [8:0]  rp_sd [DIV_STEPS+1];
	logic [32:0] qp_sd [DIV_STEPS+1];
	logic [8:0]  rt_sd [DIV_STEPS+1];
	logic [32:0] qt_sd [DIV_STEPS+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			rp_sd[0] <= (stack_i >= stk_c) ? 9'(stack_i - stk_c) : stack_i;
			qp_sd[0] <= {32'd0, stack_i >= stk_c};
			rt_sd[0] <= (sector_j >= sec_c) ? 9'(sector_j - sec_c) : sector_j;
			qt_sd[0] <= {32'd0, sector_j >= sec_c};
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [9:0] p2, t2;
		logic       pge, tge;
		assign p2  = {rp_sd[k], 1'b0};
		assign t2  = {rt_sd[k], 1'b0};
		assign pge = p2 >= {1'b0, stk_c};
		assign tge = t2 >= {1'b0, sec_c};
		always_ff @(posedge clk) begin
			if (adv) begin
				rp_sd[k+1] <= pge ? 9'(p2 - {1'b0, stk_c}) : p2[8:0];
				qp_sd[k+1] <= {qp_sd[k][31:0], pge};
				rt_sd[k+1] <= tge ? 9'(t2 - {1'b0, sec_c}) : t2[8:0];
				qt_sd[k+1] <= {qt_sd[k][31:0], tge};
			end
		end
	end

	// angle fold: phi = quarter turn - i/(2*stacks) turn, theta = j/sectors turn
	logic [31:0]     phi_a;
	uvs_pkg::fold_t  fp, ft;
	uvs_pkg::rot_t   rp_cs [CS+1];
	uvs_pkg::rot_t   rt_cs [CS+1];
	logic            np_cs [CS+1];
	logic            nt_cs [CS+1];

	assign phi_a = 32'h4000_0000 - qp_sd[DIV_STEPS][32:1];
	assign fp    = uvs_pkg::fold_angle(phi_a);
	assign ft    = uvs_pkg::fold_angle(qt_sd[DIV_STEPS][31:0]);

	always_ff @(posedge clk) begin
		if (adv) begin
			rp_cs[0] <= '{x: uvs_pkg::CORDIC_GAIN, y: 34'sd0, z: fp.z};
			rt_cs[0] <= '{x: uvs_pkg::CORDIC_GAIN, y: 34'sd0, z: ft.z};
			np_cs[0] <= fp.neg;
			nt_cs[0] <= ft.neg;
		end
	end

	// two cordic rotators side by side, one step per stage
	for (genvar k = 0; k < CS; k++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (adv) begin
				rp_cs[k+1] <= uvs_pkg::rot_step(rp_cs[k], k);
				rt_cs[k+1] <= uvs_pkg::rot_step(rt_cs[k], k);
				np_cs[k+1] <= np_cs[k];
				nt_cs[k+1] <= nt_cs[k];
			end
		end
	end

	// m0: undo the fold, cos/sin in q2.30
	logic signed [31:0] cp_m0, sp_m0, ct_m0, st_m0;
	always_ff @(posedge clk) begin
		if (adv) begin
			cp_m0 <= 32'(np_cs[CS] ? -rp_cs[CS].x : rp_cs[CS].x);
			sp_m0 <= 32'(np_cs[CS] ? -rp_cs[CS].y : rp_cs[CS].y);
			ct_m0 <= 32'(nt_cs[CS] ? -rt_cs[CS].x : rt_cs[CS].x);
			st_m0 <= 32'(nt_cs[CS] ? -rt_cs[CS].y : rt_cs[CS].y);
		end
	end

	// m1: radius and normal products
	logic signed [24:0] rad_s;
	logic signed [56:0] pxy_m1, pz_m1;
	logic signed [63:0] pnx_m1, pny_m1;
	logic signed [31:0] sp_m1, ct_m1, st_m1;

	assign rad_s = signed'({1'b0, radius_q});

	always_ff @(posedge clk) begin
		if (adv) begin
			pxy_m1 <= rad_s * cp_m0;
			pz_m1  <= rad_s * sp_m0;
			pnx_m1 <= cp_m0 * ct_m0;
			pny_m1 <= cp_m0 * st_m0;
			sp_m1  <= sp_m0;
			ct_m1  <= ct_m0;
			st_m1  <= st_m0;
		end
	end

	// m2: round the ring radius, finish z and the normal
	logic signed [26:0] xy_m2;
	logic signed [24:0] pz_m2;
	logic signed [15:0] nx_m2, ny_m2, nz_m2;
	logic signed [31:0] ct_m2, st_m2;

	always_ff @(posedge clk) begin
		if (adv) begin
			xy_m2 <= 27'((pxy_m1 + 57'sd536870912) >>> 30);
			pz_m2 <= 25'(uvs_pkg::rnd_sat(64'(pz_m1), 30, uvs_pkg::POS_LIMIT));
			nx_m2 <= 16'(uvs_pkg::rnd_sat(pnx_m1, 46, uvs_pkg::NORM_LIMIT));
			ny_m2 <= 16'(uvs_pkg::rnd_sat(pny_m1, 46, uvs_pkg::NORM_LIMIT));
			nz_m2 <= 16'(uvs_pkg::rnd_sat(64'(sp_m1), 16, uvs_pkg::NORM_LIMIT));
			ct_m2 <= ct_m1;
			st_m2 <= st_m1;
		end
	end

	// m3: ring radius times theta cos/sin
	logic signed [58:0] px_m3, py_m3;
	logic signed [24:0] pz_m3;
	logic signed [15:0] nx_m3, ny_m3, nz_m3;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_m3 <= xy_m2 * ct_m2;
			py_m3 <= xy_m2 * st_m2;
			pz_m3 <= pz_m2;
			nx_m3 <= nx_m2;
			ny_m3 <= ny_m2;
			nz_m3 <= nz_m2;
		end
	end

	// m4: output stage, held while its results drain
	logic signed [24:0] px_m4, py_m4, pz_m4;
	logic signed [15:0] nx_m4, ny_m4, nz_m4;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_m4 <= 25'(uvs_pkg::rnd_sat(64'(px_m3), 30, uvs_pkg::POS_LIMIT));
			py_m4 <= 25'(uvs_pkg::rnd_sat(64'(py_m3), 30, uvs_pkg::POS_LIMIT));
			pz_m4 <= pz_m3;
			nx_m4 <= nx_m3;
			ny_m4 <= ny_m3;
			nz_m4 <= nz_m3;
		end
	end

	// result sequencing: vertex (or reject) first, then the pending triangles
	uvs_pkg::side_t sd;
	logic [1:0]     nres;
	logic [16:0]    ca, cb, cc;
	logic           vert;

	assign sd   = side_sp[NST-1];
	assign nres = sd.rej ? 2'd1 : 2'd1 + 2'(sd.tri_a) + 2'(sd.tri_b);
	assign last_c = (sel_q == nres - 2'd1);
	assign vert = (sel_q == 2'd0) && !sd.rej;

	always_comb begin
		if (sel_q == 2'd0) begin
			ca = '0;
			cb = '0;
			cc = '0;
		end else if (sel_q == 2'd1 && sd.tri_a) begin
			ca = sd.k1;
			cb = sd.k2;
			cc = 17'(sd.k1 + 17'd1);
		end else begin
			ca = 17'(sd.k1 + 17'd1);
			cb = sd.k2;
			cc = 17'(sd.k2 + 17'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 2'd0;
		end else if (vld_q[NST-1] && m_axis_tready) begin
			sel_q <= last_c ? 2'd0 : sel_q + 2'd1;
		end
	end

	assign m_axis_tvalid = vld_q[NST-1];
	assign m_axis_tlast  = last_c;
	assign m_axis_tuser  = (sel_q != 2'd0) ? uvs_pkg::KIND_TRIANGLE :
		(sd.rej ? uvs_pkg::KIND_REJECT : uvs_pkg::KIND_VERTEX);
	assign m_axis_tdata  = {2'b00, cc, cb, ca,
		vert ? nz_m4 : 16'sd0, vert ? ny_m4 : 16'sd0, vert ? nx_m4 : 16'sd0,
		vert ? pz_m4 : 25'sd0, vert ? py_m4 : 25'sd0, vert ? px_m4 : 25'sd0};

endmodule

### sv/uvs_chk.sv
// port level checker for the uv sphere mesh generator and its bind
module uvs_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [175:0] m_axis_tdata,
	input logic [1:0]   m_axis_tuser,
	input logic         m_axis_tlast
);

	// a rejected point is a single all-zero result
	a_reject_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == uvs_pkg::KIND_REJECT)
		|-> (m_axis_tlast && m_axis_tdata == '0))
		else $error("reject result not alone or not blank");

	// triangles carry no position or normal
	a_tri_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == uvs_pkg::KIND_TRIANGLE)
		|-> (m_axis_tdata[122:0] == '0))
		else $error("triangle result carries vertex data");

	// a result that is not last is followed at once by a triangle
	a_run_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast)
		|=> (m_axis_tvalid && m_axis_tuser == uvs_pkg::KIND_TRIANGLE))
		else $error("run broken after a non-last transfer");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready)
		|=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled result changed");

endmodule

bind uv_sphere_mesh_generator uvs_chk u_uvs_chk (.*);
